// ===== sv/tick_rate_rescaler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Tick rate rescaler assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TICK_RATE_RESCALER_UNIT_ASSERT_SVH
`define TICK_RATE_RESCALER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick rate rescaler package
// Shared constants and register index codes.
// ----------------------------------------------------------------------------
package rtr_pkg;

  // Width of the rounding error output in millionths of a tick.
  localparam int unsigned ERR_W = 20;

  // Twice one million, used to scale the error fraction for half-up rounding.
  localparam int unsigned MICRO2_W = 21;
  localparam logic [MICRO2_W-1:0] MICRO2 = 21'd2000000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SRC_NUM = 2'd0,
    REG_SRC_DEN = 2'd1,
    REG_TGT_NUM = 2'd2,
    REG_TGT_DEN = 2'd3
  } reg_idx_e;

endpackage

// ===== sv/tick_rate_rescaler_unit.sv =====
// ----------------------------------------------------------------------------
// Tick rate rescaler
// Rescales a signed tick by tnum*sden / (tden*snum), rounding half away
// from zero, with saturation and an exact error report in millionths.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                     Direction
//  -------   -----------------------------------------   ---------
//  command   start_i, busy_o, tick_in_i                  in
//  result    done_o, tick_out_o, exact_o, error_micro_o  out
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,      in
//            cfg_data_i
//
// One tick is accepted in every cycle; busy_o never rises. Each tick gives
// one result through stage 0, stage 1, the main divider, the round and
// saturate stages, the error divider and the output register.
// The result strobe done_o lasts one cycle and cannot be held off, and the
// pipeline has no stall. Reset clears the valid bits and loads the rate
// registers with their reset values; no clearing pass is needed.
// Rate products are registered in the cycle after a configuration transfer.
//
module tick_rate_rescaler_unit
  import rtr_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32,
  parameter int unsigned RATE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [TICK_WIDTH-1:0] tick_in_i,
  output logic                         done_o,
  output logic signed [TICK_WIDTH-1:0] tick_out_o,
  output logic                         exact_o,
  output logic signed [ERR_W-1:0]      error_micro_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [RATE_WIDTH-1:0]        cfg_data_i
);

  `include "tick_rate_rescaler_unit_assert.svh"

  localparam int unsigned TW  = TICK_WIDTH;
  localparam int unsigned RW  = RATE_WIDTH;
  localparam int unsigned DW  = 2 * RW;          // product of two rates
  localparam int unsigned NW  = TW + 2 * RW - 1; // |tick| times rate product
  localparam int unsigned PW  = TW + 2 * RW;     // raw multiplier width
  localparam int unsigned EPW = DW + MICRO2_W;   // scaled error fraction
  localparam int unsigned N2W = EPW + 1;         // plus rounding offset

  localparam logic [RW-1:0] NUM_RST = RW'(24000);
  localparam logic [RW-1:0] DEN_RST = RW'(1);
  localparam logic [DW-1:0] PROD_RST = DW'(NUM_RST) * DW'(DEN_RST);

  localparam logic [NW:0] MAG_POS = (NW+1)'((64'd1 << (TW - 1)) - 64'd1);
  localparam logic [NW:0] MAG_NEG = (NW+1)'(64'd1 << (TW - 1));

  typedef struct packed {
    logic [TW-1:0] raw;
    logic          neg;
    logic          inval;
  } d1_tag_t;

  typedef struct packed {
    logic [TW-1:0] tick;
    logic          exact;
    logic          eneg;
    logic          zero_err;
  } d2_tag_t;

  // --------------------------------------------------------------------------
  // Configuration registers and derived rate products
  // --------------------------------------------------------------------------
  logic [RW-1:0] src_num_q, src_den_q, tgt_num_q, tgt_den_q;
  logic [DW-1:0] rprod_q;  // tnum * sden
  logic [DW-1:0] dprod_q;  // tden * snum
  logic          inval_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_num_q <= NUM_RST;
      src_den_q <= DEN_RST;
      tgt_num_q <= NUM_RST;
      tgt_den_q <= DEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SRC_NUM: src_num_q <= cfg_data_i;
        REG_SRC_DEN: src_den_q <= cfg_data_i;
        REG_TGT_NUM: tgt_num_q <= cfg_data_i;
        REG_TGT_DEN: tgt_den_q <= cfg_data_i;
        default:     src_num_q <= src_num_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rprod_q <= PROD_RST;
      dprod_q <= PROD_RST;
      inval_q <= 1'b0;
    end else begin
      rprod_q <= DW'(tgt_num_q) * DW'(src_den_q);
      dprod_q <= DW'(tgt_den_q) * DW'(src_num_q);
      inval_q <= (src_num_q == '0) || (src_den_q == '0) ||
                 (tgt_num_q == '0) || (tgt_den_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: capture the tick as sign and magnitude
  // --------------------------------------------------------------------------
  logic          s0_valid_q;
  logic [TW-1:0] s0_raw_q, s0_mag_q;
  logic          s0_neg_q;
  logic          in_neg;
  logic [TW-1:0] in_mag;

  assign in_neg = tick_in_i[TW-1];
  assign in_mag = in_neg ? (TW'(0) - tick_in_i) : tick_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_raw_q <= tick_in_i;
    s0_mag_q <= in_mag;
    s0_neg_q <= in_neg;
  end

  // --------------------------------------------------------------------------
  // Stage 1: dividend = |tick| * tnum * sden
  // --------------------------------------------------------------------------
  // The invalid-rate flag is sampled here, alongside the rate products, so
  // that a tick accepted right after a configuration transfer sees the new
  // rates throughout.
  logic          s1_valid_q;
  logic [NW-1:0] s1_num_q;
  d1_tag_t       s1_tag_q;
  logic [PW-1:0] s1_prod;

  assign s1_prod = PW'(s0_mag_q) * PW'(rprod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_q <= s1_prod[NW-1:0];
    s1_tag_q <= '{raw: s0_raw_q, neg: s0_neg_q, inval: inval_q};
  end

  // --------------------------------------------------------------------------
  // Main division: quotient and remainder of the rescaled magnitude
  // --------------------------------------------------------------------------
  logic          d1_valid;
  logic [NW-1:0] d1_quo;
  logic [DW-1:0] d1_rem, d1_den;
  d1_tag_t       d1_tag;

  rtr_divider #(
    .NUM_W(NW),
    .DEN_W(DW),
    .Q_W  (NW),
    .TAG_W($bits(d1_tag_t))
  ) u_div_main (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_valid_q),
    .num_i  (s1_num_q),
    .den_i  (dprod_q),
    .tag_i  (s1_tag_q),
    .valid_o(d1_valid),
    .quo_o  (d1_quo),
    .rem_o  (d1_rem),
    .den_o  (d1_den),
    .tag_o  (d1_tag)
  );

  // --------------------------------------------------------------------------
  // Round stage: half away from zero on the magnitude
  // --------------------------------------------------------------------------
  logic          r1_valid_q;
  logic [NW:0]   r1_rmag_q;
  logic [DW-1:0] r1_emag_q, r1_den_q;
  logic          r1_up_q, r1_rzero_q;
  d1_tag_t       r1_tag_q;
  logic          rnd_up, rnd_rzero;

  assign rnd_rzero = (d1_rem == '0);
  assign rnd_up    = !rnd_rzero && ({d1_rem, 1'b0} >= {1'b0, d1_den});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
    end else begin
      r1_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_rmag_q  <= (NW+1)'(d1_quo) + (NW+1)'(rnd_up);
    r1_emag_q  <= rnd_up ? (d1_den - d1_rem) : d1_rem;
    r1_den_q   <= d1_den;
    r1_up_q    <= rnd_up;
    r1_rzero_q <= rnd_rzero;
    r1_tag_q   <= d1_tag;
  end

  // --------------------------------------------------------------------------
  // Saturate stage: clamp, restore the sign, scale the error fraction
  // --------------------------------------------------------------------------
  logic           r2_valid_q;
  logic [EPW-1:0] r2_emul_q;
  logic [DW-1:0]  r2_den_q;
  d2_tag_t        r2_tag_q;
  logic [NW:0]    sat_mag;
  logic [TW-1:0]  sat_tick;

  always_comb begin
    if (r1_tag_q.neg) begin
      sat_mag  = (r1_rmag_q > MAG_NEG) ? MAG_NEG : r1_rmag_q;
      sat_tick = TW'(0) - sat_mag[TW-1:0];
    end else begin
      sat_mag  = (r1_rmag_q > MAG_POS) ? MAG_POS : r1_rmag_q;
      sat_tick = sat_mag[TW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_valid_q <= 1'b0;
    end else begin
      r2_valid_q <= r1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_emul_q <= EPW'(r1_emag_q) * EPW'(MICRO2);
    r2_den_q  <= r1_den_q;
    r2_tag_q  <= '{
      tick:     r1_tag_q.inval ? r1_tag_q.raw : sat_tick,
      exact:    !r1_tag_q.inval && r1_rzero_q,
      eneg:     r1_up_q ? r1_tag_q.neg : !r1_tag_q.neg,
      zero_err: r1_tag_q.inval || r1_rzero_q
    };
  end

  // --------------------------------------------------------------------------
  // Error division: (2*emag*1e6 + den) / (2*den), quotient below 2^19
  // --------------------------------------------------------------------------
  logic             d2_valid;
  logic [ERR_W-1:0] d2_quo;
  logic [DW:0]      d2_rem, d2_den;
  d2_tag_t          d2_tag;
  logic [N2W-1:0]   err_num;

  assign err_num = N2W'(r2_emul_q) + N2W'(r2_den_q);

  rtr_divider #(
    .NUM_W(N2W),
    .DEN_W(DW + 1),
    .Q_W  (ERR_W),
    .TAG_W($bits(d2_tag_t))
  ) u_div_err (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(r2_valid_q),
    .num_i  (err_num),
    .den_i  ({r2_den_q, 1'b0}),
    .tag_i  (r2_tag_q),
    .valid_o(d2_valid),
    .quo_o  (d2_quo),
    .rem_o  (d2_rem),
    .den_o  (d2_den),
    .tag_o  (d2_tag)
  );

  // --------------------------------------------------------------------------
  // Output register: sign the error and strobe the result transfer
  // --------------------------------------------------------------------------
  logic             done_q;
  logic [TW-1:0]    tick_out_q;
  logic             exact_q;
  logic [ERR_W-1:0] err_q, err_d;

  always_comb begin
    if (d2_tag.zero_err) begin
      err_d = '0;
    end else if (d2_tag.eneg) begin
      err_d = ERR_W'(0) - d2_quo;
    end else begin
      err_d = d2_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_out_q <= d2_tag.tick;
    exact_q    <= d2_tag.exact;
    err_q      <= err_d;
  end

  assign done_o        = done_q;
  assign tick_out_o    = tick_out_q;
  assign exact_o       = exact_q;
  assign error_micro_o = err_q;

  // The error divider remainder is not needed past the last stage; fold it into
  // a check that it stays below the error divisor (or that divisor is zero).
  logic err_rem_ok;
  assign err_rem_ok = (d2_rem < d2_den) || (d2_den == '0);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RTR_ASSERT_IMPL(a_exact_no_err, done_o && exact_o, error_micro_o == '0,
                   "exact result carries a nonzero error")
  `RTR_ASSERT_IMPL(a_err_range, done_o,
                   (error_micro_o >= -20'sd500000) && (error_micro_o <= 20'sd500000),
                   "error outside half a tick")
  `RTR_ASSERT_NEXT(a_done_follows, d2_valid && err_rem_ok, done_o,
                   "finished item did not reach the result port")

endmodule

// ===== sv/rtr_div_stage.sv =====
// ----------------------------------------------------------------------------
// Restoring divider stage
// Resolves one quotient bit per stage and registers the partial result.
// ----------------------------------------------------------------------------
module rtr_div_stage #(
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 64,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   lq_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [Q_W-1:0]   lq_o,
  output logic [DEN_W-1:0] den_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic             valid_q;
  logic [DEN_W-1:0] rem_d, rem_q;
  logic [Q_W-1:0]   lq_d, lq_q;
  logic [DEN_W-1:0] den_q;
  logic [TAG_W-1:0] tag_q;

  // The next dividend bit leaves the top of lq while the quotient bit
  // enters at the bottom.
  assign trial = {rem_i, lq_i[Q_W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = (trial >= {1'b0, den_i});
  assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign lq_d  = {lq_i[Q_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lq_q  <= lq_d;
    den_q <= den_i;
    tag_q <= tag_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign lq_o    = lq_q;
  assign den_o   = den_q;
  assign tag_o   = tag_q;

endmodule

// ===== sv/rtr_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the caller guarantees the quotient fits Q_W.
// ----------------------------------------------------------------------------
module rtr_divider #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 64,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             valid_s [Q_W+1];
  logic [DEN_W-1:0] rem_s   [Q_W+1];
  logic [Q_W-1:0]   lq_s    [Q_W+1];
  logic [DEN_W-1:0] den_s   [Q_W+1];
  logic [TAG_W-1:0] tag_s   [Q_W+1];

  // High dividend bits above the quotient range seed the remainder; they
  // are below the divisor by construction.
  generate
    if (NUM_W > Q_W) begin : g_seed
      assign rem_s[0] = DEN_W'(num_i[NUM_W-1:Q_W]);
    end else begin : g_zero
      assign rem_s[0] = '0;
    end
  endgenerate

  assign valid_s[0] = valid_i;
  assign lq_s[0]    = num_i[Q_W-1:0];
  assign den_s[0]   = den_i;
  assign tag_s[0]   = tag_i;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    rtr_div_stage #(
      .DEN_W(DEN_W),
      .Q_W  (Q_W),
      .TAG_W(TAG_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .rem_i  (rem_s[i]),
      .lq_i   (lq_s[i]),
      .den_i  (den_s[i]),
      .tag_i  (tag_s[i]),
      .valid_o(valid_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .lq_o   (lq_s[i+1]),
      .den_o  (den_s[i+1]),
      .tag_o  (tag_s[i+1])
    );
  end

  assign valid_o = valid_s[Q_W];
  assign quo_o   = lq_s[Q_W];
  assign rem_o   = rem_s[Q_W];
  assign den_o   = den_s[Q_W];
  assign tag_o   = tag_s[Q_W];

endmodule
